// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the S-record encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
// Checks that a condition in one cycle is followed by another in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/sbsrec_pkg.sv -----
// Types, constants and helper functions of the S-record encoder.
`timescale 1ns / 1ps
package sbsrec_pkg;

    localparam int MAX_RECORD_DATA_DEF = 32;

    localparam logic [7:0] TRAILER_TYPE = 8'hFF;
    localparam logic [7:0] RECORD_EXTRA = 8'h03;
    localparam logic [7:0] CH_S         = 8'h53;
    localparam logic [7:0] CH_ONE       = 8'h31;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_NONE      = 8'h00;

    localparam logic [1:0] PAIR_ONE     = 2'd1;
    localparam logic [1:0] PAIR_TWO     = 2'd2;

    // Position in the segment header and data.
    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_DATA
    } t_phase;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Character pair of a record being sent.
    typedef enum logic [2:0] {
        PC_HEAD,
        PC_COUNT,
        PC_ADDR_HI,
        PC_ADDR_LO,
        PC_DATA,
        PC_SUM,
        PC_EOL
    } t_piece;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] wide;
        wide = {4'h0, v};
        return (v < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
    endfunction

endpackage

// ----- rtl/segmented_binary_to_srecord.sv -----
// Top level of the segmented binary to S-record text encoder.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Header, length, address and data bytes that produce no text are taken with no stall. A
// byte that ends a record of n data bytes, or an S9 trailer, holds the input while its n + 6
// pairs go out, one pair a cycle from the record buffer memory unless the output stalls; the
// first pair is loaded from the record registered at the transfer. The input is taken again
// as soon as the last pair sits in the output register. Synchronous active-low reset clears
// the parser, the sequencer and the output valid; the record buffer is not cleared.
module segmented_binary_to_srecord #(
    parameter int MAX_RECORD_DATA = sbsrec_pkg::MAX_RECORD_DATA_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_file,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_char_first,
    output logic [7:0] o_char_second,
    output logic [1:0] o_char_count,
    output logic       o_last_of_run
);
    import sbsrec_pkg::*;

    localparam int CW = $clog2(MAX_RECORD_DATA + 1);
    localparam int AW = (MAX_RECORD_DATA > 1) ? $clog2(MAX_RECORD_DATA) : 1;

    // Parser state.
    t_phase      r_phase, n_phase;
    logic        r_trailer, n_trailer;
    logic [15:0] r_remain, n_remain;
    logic [15:0] r_addr, n_addr;
    logic [CW-1:0] r_fill, n_fill;
    logic [7:0]  r_dsum, n_dsum;
    logic        r_finished, n_finished;

    // Record handed to the sequencer.
    logic          emit_go;
    logic          emit_s9;
    logic [CW-1:0] emit_cnt;
    logic [15:0]   emit_addr;
    logic [7:0]    emit_dsum;
    logic [7:0]    emit_cc;

    logic [CW-1:0] fill_inc;
    logic [7:0]    dsum_inc;
    logic [15:0]   remain_dec;

    // Sequencer state.
    t_state        r_state, n_state;
    t_piece        r_piece, n_piece;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] rd_next;
    logic          r_rec_s9;
    logic [CW-1:0] r_rec_cnt;
    logic [15:0]   r_rec_addr;
    logic [7:0]    r_rec_sum;
    logic [7:0]    r_rec_cc;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_char_first, n_char_first;
    logic [7:0] r_char_second, n_char_second;
    logic [1:0] r_char_count, n_char_count;
    logic       r_last, n_last;
    logic       load;

    // Record buffer.
    logic [7:0] r_mem [MAX_RECORD_DATA];
    logic [7:0] r_mem_q;
    logic       mem_we;

    logic in_xfer;

    assign o_stall = (r_state != ST_IDLE);
    assign in_xfer = i_valid && !o_stall;
    assign mem_we  = in_xfer && !r_finished && (r_phase == PH_DATA);

    assign fill_inc   = r_fill + CW'(1);
    assign dsum_inc   = r_dsum + i_data_byte;
    assign remain_dec = r_remain - 16'd1;

    always_comb begin
        n_phase    = r_phase;
        n_trailer  = r_trailer;
        n_remain   = r_remain;
        n_addr     = r_addr;
        n_fill     = r_fill;
        n_dsum     = r_dsum;
        n_finished = r_finished;
        emit_go    = 1'b0;
        emit_s9    = 1'b0;
        emit_cnt   = r_fill;
        emit_addr  = r_addr;
        emit_dsum  = r_dsum;
        if (!r_finished) begin
            case (r_phase)
                PH_TYPE: begin
                    n_trailer = (i_data_byte == TRAILER_TYPE);
                    n_phase   = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_remain = {i_data_byte, 8'h00};
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_remain = {r_remain[15:8], i_data_byte};
                    n_phase  = PH_ADDR_HI;
                end
                PH_ADDR_HI: begin
                    n_addr  = {i_data_byte, 8'h00};
                    n_phase = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                    n_addr = {r_addr[15:8], i_data_byte};
                    n_fill = '0;
                    n_dsum = 8'h00;
                    if (r_trailer) begin
                        emit_go    = 1'b1;
                        emit_s9    = 1'b1;
                        emit_cnt   = '0;
                        emit_addr  = n_addr;
                        emit_dsum  = 8'h00;
                        n_finished = 1'b1;
                        n_phase    = PH_TYPE;
                    end else begin
                        n_phase = (r_remain == 16'd0) ? PH_TYPE : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_remain = remain_dec;
                    if (fill_inc == CW'(MAX_RECORD_DATA) || remain_dec == 16'd0) begin
                        emit_go   = 1'b1;
                        emit_cnt  = fill_inc;
                        emit_addr = r_addr;
                        emit_dsum = dsum_inc;
                        n_addr    = r_addr + 16'(fill_inc);
                        n_fill    = '0;
                        n_dsum    = 8'h00;
                        if (remain_dec == 16'd0) begin
                            n_phase = PH_TYPE;
                        end
                    end else begin
                        n_fill = fill_inc;
                        n_dsum = dsum_inc;
                    end
                end
                default: begin
                    n_phase = PH_TYPE;
                end
            endcase
        end
        if (i_end_of_file) begin
            // A record emitted above always leaves the fill count at zero, so at most
            // one record comes out of one transfer.
            if (n_fill != '0) begin
                emit_go   = 1'b1;
                emit_s9   = 1'b0;
                emit_cnt  = n_fill;
                emit_addr = n_addr;
                emit_dsum = n_dsum;
            end
            n_phase    = PH_TYPE;
            n_trailer  = 1'b0;
            n_remain   = 16'd0;
            n_addr     = 16'd0;
            n_fill     = '0;
            n_dsum     = 8'h00;
            n_finished = 1'b0;
        end
    end

    assign emit_cc = 8'(emit_cnt) + RECORD_EXTRA;
    assign rd_next = r_rd_idx + CW'(1);
    assign load    = (r_state == ST_EMIT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state       = r_state;
        n_piece       = r_piece;
        n_rd_idx      = r_rd_idx;
        n_char_first  = hex_char(r_rec_cc[7:4]);
        n_char_second = hex_char(r_rec_cc[3:0]);
        n_char_count  = PAIR_TWO;
        n_last        = 1'b0;
        if (in_xfer) begin
            n_rd_idx = '0;
            if (emit_go) begin
                n_state = ST_EMIT;
                n_piece = PC_HEAD;
            end
        end
        if (r_state == ST_EMIT) begin
            case (r_piece)
                PC_HEAD: begin
                    n_char_first  = CH_S;
                    n_char_second = r_rec_s9 ? CH_NINE : CH_ONE;
                    if (load) n_piece = PC_COUNT;
                end
                PC_COUNT: begin
                    if (load) n_piece = PC_ADDR_HI;
                end
                PC_ADDR_HI: begin
                    n_char_first  = hex_char(r_rec_addr[15:12]);
                    n_char_second = hex_char(r_rec_addr[11:8]);
                    if (load) n_piece = PC_ADDR_LO;
                end
                PC_ADDR_LO: begin
                    n_char_first  = hex_char(r_rec_addr[7:4]);
                    n_char_second = hex_char(r_rec_addr[3:0]);
                    if (load) n_piece = (r_rec_cnt == '0) ? PC_SUM : PC_DATA;
                end
                PC_DATA: begin
                    n_char_first  = hex_char(r_mem_q[7:4]);
                    n_char_second = hex_char(r_mem_q[3:0]);
                    if (load) begin
                        if (rd_next == r_rec_cnt) begin
                            n_piece = PC_SUM;
                        end else begin
                            n_rd_idx = rd_next;
                        end
                    end
                end
                PC_SUM: begin
                    n_char_first  = hex_char(~r_rec_sum[7:4]);
                    n_char_second = hex_char(~r_rec_sum[3:0]);
                    if (load) n_piece = PC_EOL;
                end
                PC_EOL: begin
                    n_char_first  = CH_NEWLINE;
                    n_char_second = CH_NONE;
                    n_char_count  = PAIR_ONE;
                    n_last        = 1'b1;
                    if (load) n_state = ST_IDLE;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TYPE;
            r_trailer  <= 1'b0;
            r_remain   <= 16'd0;
            r_addr     <= 16'd0;
            r_fill     <= '0;
            r_dsum     <= 8'h00;
            r_finished <= 1'b0;
        end else if (in_xfer) begin
            r_phase    <= n_phase;
            r_trailer  <= n_trailer;
            r_remain   <= n_remain;
            r_addr     <= n_addr;
            r_fill     <= n_fill;
            r_dsum     <= n_dsum;
            r_finished <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_piece     <= PC_HEAD;
            r_rd_idx    <= '0;
            r_rec_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_piece  <= n_piece;
            r_rd_idx <= n_rd_idx;
            if (in_xfer && emit_go) begin
                r_rec_cnt <= emit_cnt;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && emit_go) begin
            r_rec_s9   <= emit_s9;
            r_rec_addr <= emit_addr;
            r_rec_cc   <= emit_cc;
            r_rec_sum  <= emit_cc + emit_addr[15:8] + emit_addr[7:0] + emit_dsum;
        end
        if (load) begin
            r_char_first  <= n_char_first;
            r_char_second <= n_char_second;
            r_char_count  <= n_char_count;
            r_last        <= n_last;
        end
    end

    // The buffer is read every cycle at the next index. A write and a read of the same
    // entry at the transfer edge return old data, but the read is repeated while the header
    // pairs are sent, so the new byte is picked up before it is sent.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_fill[AW-1:0]] <= i_data_byte;
        end
        r_mem_q <= r_mem[n_rd_idx[AW-1:0]];
    end

    assign o_valid       = r_out_valid;
    assign o_char_first  = r_char_first;
    assign o_char_second = r_char_second;
    assign o_char_count  = r_char_count;
    assign o_last_of_run = r_last;

    `ASSERT_NEXT(a_eol_ends_record, load && (r_piece == PC_EOL), r_state == ST_IDLE, "newline did not end the record")
    `ASSERT_ALWAYS(a_rd_in_record, r_rd_idx <= r_rec_cnt, "buffer read index beyond record")
    `ASSERT_ALWAYS(a_fill_below_full, r_fill < CW'(MAX_RECORD_DATA), "full record kept in buffer")
    `ASSERT_ALWAYS(a_single_is_last, !r_out_valid || ((r_char_count == PAIR_ONE) == r_last), "single character not at end of run")
    `ASSERT_ALWAYS(a_finished_idle_parse, !r_finished || (r_phase == PH_TYPE), "parser moved after trailer")

endmodule
